### rtl/esd_pkg.sv
// Shared types and constants of the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

    // Escape character after reset: '^'
    localparam logic [7:0] ESC_RESET = 8'h5E;

    // Characters the decoder reacts to
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Control codes produced by the letter escapes
    localparam logic [7:0] CTL_BEL = 8'd7;
    localparam logic [7:0] CTL_BS  = 8'd8;
    localparam logic [7:0] CTL_ESC = 8'd27;
    localparam logic [7:0] CTL_FF  = 8'd12;
    localparam logic [7:0] CTL_LF  = 8'd10;
    localparam logic [7:0] CTL_CR  = 8'd13;
    localparam logic [7:0] CTL_HT  = 8'd9;
    localparam logic [7:0] CTL_VT  = 8'd11;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_HEX   = 4'b0100,
        MODE_DEC   = 4'b1000
    } t_mode;

    // One decoded command: one or two result words
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic       first_bad;
        logic [7:0] second;
    } t_cmd;

endpackage

### rtl/escape_sequence_decoder.sv
// Top level of the escape sequence decoder.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | i_in_valid / o_in_stall   | i_char_in, i_end_of_text
//  output   | o_out_valid / i_out_stall | o_byte_out, o_bad_escape, o_last
//  config   | i_cfg_valid / o_cfg_ready | i_escape_char
//
// One input word per cycle while the queue has room; a word that yields two
// results holds the output stage for both; the output register sets the rate.
// The four-entry command queue absorbs those doubles and output stalls;
// o_in_stall rises only when the queue is full.
// Synchronous active-low reset clears mode, accumulator, queue and output.
`timescale 1ns / 1ps

module escape_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_escape_char,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_byte_out,
    output logic       o_bad_escape,
    output logic       o_last
);

    esd_pkg::t_cmd push_cmd;
    esd_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    esd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_escape_char (i_escape_char),
        .i_accept      (accept),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    esd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_out   (o_byte_out),
        .o_bad_escape (o_bad_escape),
        .o_last       (o_last)
    );

endmodule

### rtl/esd_front.sv
// Front end: accepts input words, tracks escape state, issues result commands.
`timescale 1ns / 1ps

module esd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_escape_char,
    input  logic          i_accept,
    input  logic [7:0]    i_char_in,
    input  logic          i_end_of_text,
    output logic          o_push,
    output esd_pkg::t_cmd o_cmd
);

    esd_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_accum, n_accum;
    logic [7:0]     r_esc;
    logic [1:0]     cnt;
    logic           is_dec;
    logic           is_hex;
    logic [3:0]     hex_val;
    logic [7:0]     b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= esd_pkg::MODE_PLAIN;
            r_accum <= 8'd0;
            r_esc   <= esd_pkg::ESC_RESET;
        end else begin
            if (i_accept) begin
                r_mode  <= n_mode;
                r_accum <= n_accum;
            end
            if (i_cfg_valid) begin
                r_esc <= i_escape_char;
            end
        end
    end

    assign b = i_char_in;

    always_comb begin
        is_dec  = (b >= esd_pkg::CH_0) && (b <= esd_pkg::CH_9);
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (is_dec) begin
            hex_val = 4'(b - esd_pkg::CH_0);
        end else if ((b >= esd_pkg::CH_LA) && (b <= esd_pkg::CH_LF)) begin
            hex_val = 4'(b - esd_pkg::CH_LA + 8'd10);
        end else if ((b >= esd_pkg::CH_UA) && (b <= esd_pkg::CH_UF)) begin
            hex_val = 4'(b - esd_pkg::CH_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        n_mode             = r_mode;
        n_accum            = r_accum;
        cnt                = 2'd0;
        o_cmd.two          = 1'b0;
        o_cmd.first        = 8'd0;
        o_cmd.first_bad    = 1'b0;
        o_cmd.second       = b;
        if (i_end_of_text) begin
            if (r_mode == esd_pkg::MODE_ESC) begin
                cnt             = 2'd1;
                o_cmd.first_bad = 1'b1;
            end else if (r_mode != esd_pkg::MODE_PLAIN) begin
                cnt         = 2'd1;
                o_cmd.first = r_accum;
            end
            n_mode  = esd_pkg::MODE_PLAIN;
            n_accum = 8'd0;
        end else begin
            case (r_mode)
                esd_pkg::MODE_PLAIN: begin
                    if (b == r_esc) begin
                        n_mode = esd_pkg::MODE_ESC;
                    end else begin
                        cnt         = 2'd1;
                        o_cmd.first = b;
                    end
                end
                esd_pkg::MODE_ESC: begin
                    n_mode = esd_pkg::MODE_PLAIN;
                    cnt    = 2'd1;
                    if (b == r_esc) begin
                        o_cmd.first = b;
                    end else begin
                        case (b)
                            esd_pkg::CH_LA: o_cmd.first = esd_pkg::CTL_BEL;
                            esd_pkg::CH_LB: o_cmd.first = esd_pkg::CTL_BS;
                            esd_pkg::CH_LE: o_cmd.first = esd_pkg::CTL_ESC;
                            esd_pkg::CH_LF: o_cmd.first = esd_pkg::CTL_FF;
                            esd_pkg::CH_LN: o_cmd.first = esd_pkg::CTL_LF;
                            esd_pkg::CH_LR: o_cmd.first = esd_pkg::CTL_CR;
                            esd_pkg::CH_LT: o_cmd.first = esd_pkg::CTL_HT;
                            esd_pkg::CH_LV: o_cmd.first = esd_pkg::CTL_VT;
                            esd_pkg::CH_QUOTE, esd_pkg::CH_DQUOT, esd_pkg::CH_PCT: begin
                                o_cmd.first = b;
                            end
                            esd_pkg::CH_LX: begin
                                n_mode  = esd_pkg::MODE_HEX;
                                n_accum = 8'd0;
                                cnt     = 2'd0;
                            end
                            default: begin
                                if (is_dec) begin
                                    n_mode  = esd_pkg::MODE_DEC;
                                    n_accum = 8'(b - esd_pkg::CH_0);
                                    cnt     = 2'd0;
                                end else begin
                                    // unknown escape: flag a zero, then pass the byte
                                    cnt             = 2'd2;
                                    o_cmd.first_bad = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                esd_pkg::MODE_HEX, esd_pkg::MODE_DEC: begin
                    if ((r_mode == esd_pkg::MODE_HEX) && is_hex) begin
                        n_accum = {r_accum[3:0], hex_val};
                    end else if ((r_mode == esd_pkg::MODE_DEC) && is_dec) begin
                        n_accum = 8'({r_accum, 3'b000} + {r_accum, 1'b0}
                                     + (b - esd_pkg::CH_0));
                    end else begin
                        // run ends: emit its value, swallow one semicolon, else treat the byte as plain
                        cnt         = 2'd1;
                        o_cmd.first = r_accum;
                        n_mode      = esd_pkg::MODE_PLAIN;
                        n_accum     = 8'd0;
                        if (b != esd_pkg::CH_SEMI) begin
                            if (b == r_esc) begin
                                n_mode = esd_pkg::MODE_ESC;
                            end else begin
                                cnt = 2'd2;
                            end
                        end
                    end
                end
                default: begin
                    n_mode  = esd_pkg::MODE_PLAIN;
                    n_accum = 8'd0;
                end
            endcase
        end
        o_cmd.two = (cnt == 2'd2);
    end

    assign o_push = i_accept && (cnt != 2'd0);

endmodule

### rtl/esd_queue.sv
// Short command queue between the front end and the output stage.
`timescale 1ns / 1ps

module esd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esd_pkg::t_cmd i_wdata,
    input  logic          i_pop,
    output esd_pkg::t_cmd o_rdata,
    output logic          o_full,
    output logic          o_empty
);

    esd_pkg::t_cmd                r_mem [esd_pkg::QDEPTH];
    logic [esd_pkg::QPTR_W-1:0]   r_wptr;
    logic [esd_pkg::QPTR_W-1:0]   r_rptr;
    logic [esd_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == esd_pkg::QLAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == esd_pkg::QLAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == esd_pkg::QFULL);
    assign o_empty = (r_count == '0);

endmodule

### rtl/esd_back.sv
// Output stage: expands queued commands into result words.
`timescale 1ns / 1ps

module esd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esd_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_byte_out,
    output logic          o_bad_escape,
    output logic          o_last
);

    logic       r_valid;
    logic       r_phase;
    logic [7:0] r_byte;
    logic       r_bad;
    logic       r_last;
    logic       load;
    logic       first_half;

    // advance when the output register is free or being taken
    assign load       = !i_empty && (!r_valid || !i_out_stall);
    assign first_half = i_cmd.two && !r_phase;
    assign o_pop      = load && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= first_half;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_phase ? i_cmd.second : i_cmd.first;
            r_bad  <= r_phase ? 1'b0 : i_cmd.first_bad;
            r_last <= !first_half;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_byte_out   = r_byte;
    assign o_bad_escape = r_bad;
    assign o_last       = r_last;

endmodule

### test/escape_sequence_decoder_tb.sv
// Self-checking testbench of the escape sequence decoder.
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] DEFAULT_ESCAPE = 8'h5E;

    localparam logic [7:0] C_0       = 8'h30;
    localparam logic [7:0] C_9       = 8'h39;
    localparam logic [7:0] C_UA      = 8'h41;
    localparam logic [7:0] C_UF      = 8'h46;
    localparam logic [7:0] C_LA      = 8'h61;
    localparam logic [7:0] C_LB      = 8'h62;
    localparam logic [7:0] C_LE      = 8'h65;
    localparam logic [7:0] C_LF      = 8'h66;
    localparam logic [7:0] C_LN      = 8'h6E;
    localparam logic [7:0] C_LR      = 8'h72;
    localparam logic [7:0] C_LT      = 8'h74;
    localparam logic [7:0] C_LV      = 8'h76;
    localparam logic [7:0] C_LX      = 8'h78;
    localparam logic [7:0] C_QUOTE   = 8'h27;
    localparam logic [7:0] C_DQUOTE  = 8'h22;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_SEMI    = 8'h3B;

    localparam logic [7:0] CTL_BEL = 8'd7;
    localparam logic [7:0] CTL_BS  = 8'd8;
    localparam logic [7:0] CTL_ESC = 8'd27;
    localparam logic [7:0] CTL_FF  = 8'd12;
    localparam logic [7:0] CTL_LF  = 8'd10;
    localparam logic [7:0] CTL_CR  = 8'd13;
    localparam logic [7:0] CTL_HT  = 8'd9;
    localparam logic [7:0] CTL_VT  = 8'd11;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } t_dec_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_escape_char;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_in;
    logic       i_end_of_text;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_byte_out;
    logic       o_bad_escape;
    logic       o_last;

    // decoder state as predicted
    esd_pkg::t_mode dec_mode;
    logic [7:0]     run_value;
    logic [7:0]     escape_cfg;

    t_dec_word expected_words[$];
    int        mismatch_count = 0;
    int        words_sent     = 0;
    int        cycle_count    = 0;
    int        hold_cycles    = 0;
    bit        in_gaps_on     = 1'b1;
    bit        out_gaps_on    = 1'b1;

    escape_sequence_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_escape_char (i_escape_char),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_byte_out    (o_byte_out),
        .o_bad_escape  (o_bad_escape),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("escape_sequence_decoder regression: fail");
        $finish;
    end

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    // Advance the predicted state by one accepted word and queue its results.
    function automatic void predict_word(input logic [7:0] b, input logic eot);
        t_dec_word  res [2];
        int         n;
        logic       as_plain;
        logic [7:0] h;
        n = 0;
        as_plain = 1'b0;
        if (eot) begin
            if (dec_mode == esd_pkg::MODE_ESC) begin
                res[n] = '{8'h00, 1'b1, 1'b0};
                n++;
            end else if (dec_mode != esd_pkg::MODE_PLAIN) begin
                res[n] = '{run_value, 1'b0, 1'b0};
                n++;
            end
            dec_mode = esd_pkg::MODE_PLAIN;
            run_value = 8'h00;
        end else if (dec_mode == esd_pkg::MODE_PLAIN) begin
            as_plain = 1'b1;
        end else if (dec_mode == esd_pkg::MODE_ESC) begin
            dec_mode = esd_pkg::MODE_PLAIN;
            if (b == escape_cfg) begin
                res[n] = '{b, 1'b0, 1'b0};
                n++;
            end else begin
                h = 8'h00;
                case (b)
                    C_LA: h = CTL_BEL;
                    C_LB: h = CTL_BS;
                    C_LE: h = CTL_ESC;
                    C_LF: h = CTL_FF;
                    C_LN: h = CTL_LF;
                    C_LR: h = CTL_CR;
                    C_LT: h = CTL_HT;
                    C_LV: h = CTL_VT;
                    C_QUOTE, C_DQUOTE, C_PERCENT: h = b;
                    C_LX: begin
                        dec_mode = esd_pkg::MODE_HEX;
                        run_value = 8'h00;
                    end
                    default: begin
                        if (b >= C_0 && b <= C_9) begin
                            dec_mode = esd_pkg::MODE_DEC;
                            run_value = b - C_0;
                        end else begin
                            // unknown escape: flag it, then take the byte as text
                            res[n] = '{8'h00, 1'b1, 1'b0};
                            n++;
                            as_plain = 1'b1;
                        end
                    end
                endcase
                if (dec_mode == esd_pkg::MODE_PLAIN && !as_plain) begin
                    res[n] = '{h, 1'b0, 1'b0};
                    n++;
                end
            end
        end else begin
            if (dec_mode == esd_pkg::MODE_HEX && b >= C_0 && b <= C_9) begin
                run_value = {run_value[3:0], b[3:0]};
            end else if (dec_mode == esd_pkg::MODE_HEX && b >= C_LA && b <= C_LF) begin
                h = b - C_LA + 8'd10;
                run_value = {run_value[3:0], h[3:0]};
            end else if (dec_mode == esd_pkg::MODE_HEX && b >= C_UA && b <= C_UF) begin
                h = b - C_UA + 8'd10;
                run_value = {run_value[3:0], h[3:0]};
            end else if (dec_mode == esd_pkg::MODE_DEC && b >= C_0 && b <= C_9) begin
                run_value = 8'(int'(run_value) * 10 + int'(b - C_0));
            end else begin
                // run ends: emit its value, swallow one semicolon
                res[n] = '{run_value, 1'b0, 1'b0};
                n++;
                dec_mode = esd_pkg::MODE_PLAIN;
                run_value = 8'h00;
                as_plain = (b != C_SEMI);
            end
        end
        if (as_plain) begin
            if (b == escape_cfg) begin
                dec_mode = esd_pkg::MODE_ESC;
            end else begin
                res[n] = '{b, 1'b0, 1'b0};
                n++;
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_words.push_back(res[k]);
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_word(input logic [7:0] c, input logic eot);
        int gap;
        if (in_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            i_char_in <= 8'($urandom);
            i_end_of_text <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(c, eot);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_escape(input logic [7:0] c);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_escape_char <= c;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        escape_cfg = c;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed sequences with random content, some noise.
    task automatic send_random(input int count);
        int         start;
        int         kind;
        int         k;
        logic [7:0] c;
        start = words_sent;
        while (words_sent - start < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                send_word(8'($urandom), 1'b0);
            end else if (kind < 40) begin
                send_word(escape_cfg, 1'b0);
                k = $urandom_range(0, 11);
                case (k)
                    0: c = C_LA;
                    1: c = C_LB;
                    2: c = C_LE;
                    3: c = C_LF;
                    4: c = C_LN;
                    5: c = C_LR;
                    6: c = C_LT;
                    7: c = C_LV;
                    8: c = C_QUOTE;
                    9: c = C_DQUOTE;
                    10: c = C_PERCENT;
                    default: c = escape_cfg;
                endcase
                send_word(c, 1'b0);
            end else if (kind < 70) begin
                send_word(escape_cfg, 1'b0);
                if (kind < 55) begin
                    send_word(C_LX, 1'b0);
                    repeat ($urandom_range(0, 4)) begin
                        k = $urandom_range(0, 21);
                        if (k < 10) c = C_0 + 8'(k);
                        else if (k < 16) c = C_LA + 8'(k - 10);
                        else c = C_UA + 8'(k - 16);
                        send_word(c, 1'b0);
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) send_word(C_0 + 8'($urandom_range(0, 9)), 1'b0);
                end
                case ($urandom_range(0, 3))
                    0: send_word(C_SEMI, 1'b0);
                    1: send_word(8'($urandom), 1'b0);
                    2: send_word(8'($urandom), 1'b1);
                    default: send_word(escape_cfg, 1'b0);
                endcase
            end else if (kind < 78) begin
                send_word(escape_cfg, 1'b0);
                send_word(8'($urandom), 1'b0);
            end else if (kind < 85) begin
                send_word(8'($urandom), 1'b1);
            end else if (kind < 90) begin
                send_word(escape_cfg, 1'b0);
                send_word(8'($urandom), 1'b1);
            end else begin
                send_word($urandom_range(0, 1) ? escape_cfg : 8'($urandom), 1'b0);
            end
        end
    endtask

    // Runs with the reset escape character, so it also checks that value.
    task automatic test_directed();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("^a^v^\"^%^^");
        send_text("^xFa;^299z");
        send_text("^q^xq^7^n");
        send_word(8'h00, 1'b1);
        send_text("^");
        send_word(8'hFF, 1'b1);
        send_text("^x3");
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_random_default();
        send_random(300);
    endtask

    // Escape characters at the extremes and ones that collide with run digits or run syntax.
    task automatic test_escape_settings();
        write_escape(8'h00);
        send_random(150);
        write_escape(8'hFF);
        send_random(150);
        write_escape(C_LA);
        send_random(150);
        write_escape(C_0 + 8'd5);
        send_random(150);
        write_escape(C_LX);
        send_random(150);
        write_escape(C_SEMI);
        send_random(150);
        write_escape(DEFAULT_ESCAPE);
    endtask

    task automatic test_backpressure();
        in_gaps_on = 1'b0;
        hold_cycles = 80;
        send_random(60);
        // pause the sender until every result is in
        wait_drained();
        send_random(40);
        in_gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
        send_random(350);
    endtask

    // Output stall: long hold when requested, none when gaps are off, else random bursts and free runs.
    initial begin
        int burst;
        int run;
        burst = 0;
        run = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (!out_gaps_on) begin
                i_out_stall <= 1'b0;
            end else if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else if (run > 0) begin
                i_out_stall <= 1'b0;
                run--;
            end else if ($urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 9) - 1;
                i_out_stall <= 1'b1;
            end else begin
                run = $urandom_range(1, 40) - 1;
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dec_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word: byte %02h bad %0b last %0b",
                                          o_byte_out, o_bad_escape, o_last));
            end else begin
                want = expected_words.pop_front();
                if (o_byte_out !== want.data || o_bad_escape !== want.bad ||
                    o_last !== want.last) begin
                    report_mismatch($sformatf(
                        "expected %02h bad %0b last %0b, got %02h bad %0b last %0b",
                        want.data, want.bad, want.last, o_byte_out, o_bad_escape, o_last));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_escape_char = 8'h00;
        i_in_valid = 1'b0;
        i_char_in = 8'h00;
        i_end_of_text = 1'b0;
        dec_mode = esd_pkg::MODE_PLAIN;
        run_value = 8'h00;
        escape_cfg = DEFAULT_ESCAPE;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_default();
        test_escape_settings();
        test_backpressure();
        test_steady_stream();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("escape_sequence_decoder regression: pass");
        end else begin
            $display("escape_sequence_decoder regression: fail");
        end
        $finish;
    end

endmodule
